### design/tmt_pkg.sv
// ----------------------------------------------------------------------------
// tmt_pkg: shared types and constants of the trapezoid move time block
// axis limits, fixed-point constants and the sequencer state type
// ----------------------------------------------------------------------------
`default_nettype none

package tmt_pkg;

   localparam logic [2:0]  JOINT_AXES     = 3'd6;
   localparam logic [2:0]  LINEAR_AXES    = 3'd4;
   localparam logic [2:0]  AXIS_COUNT_MAX = 3'd7;
   localparam logic [31:0] TINY_LIMIT_RAW = 32'd7;
   localparam logic [31:0] FLOOR_TIME_RAW = 32'd2621;
   localparam logic [6:0]  DIV_SHORT_STEPS = 7'd48;
   localparam logic [6:0]  DIV_LONG_STEPS  = 7'd64;
   localparam logic [6:0]  SQRT_STEPS      = 7'd32;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHECK,
      ST_MUL_VV,
      ST_MUL_SA,
      ST_COMPARE,
      ST_DIV_ACCEL,
      ST_DIV_CRUISE,
      ST_DIV_RATIO,
      ST_SQRT,
      ST_UPDATE
   } state_type;

endpackage

`default_nettype wire

### design/trapezoid_move_time.sv
// ----------------------------------------------------------------------------
// trapezoid_move_time: longest trapezoidal profile time over the axes of a move
//
// One req_ transfer carries one axis: signed Q16.16 distance, speed and
// acceleration limits, the linear mode bit and the last-axis mark. For each
// counted axis the time is v/a + |S|/v when the speed limit is reached, else
// 2*sqrt(|S|/a). The maximum over counted axes (six in joint mode, four in
// linear mode) and an error flag leave on the rsp_ channel after the last axis.
// An axis with zero distance, a zero limit or that does not count goes from
// the check straight to the update; a full axis runs the shared bit-serial
// divide/square-root unit (48 + 48 steps, or 64 + 32 steps). req_stall is high
// for the whole axis; one axis at a time is in flight.
// The result sits in an output register; while rsp_stall holds it, the next
// axis is already accepted and computed, and only a following last axis waits.
// Reset (synchronous, active high) clears the running maximum, axis count,
// error flag and any pending result.
// ----------------------------------------------------------------------------
`default_nettype none

module trapezoid_move_time
   import tmt_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic signed [31:0] req_distance,
   input  wire logic        [31:0] req_speed_limit,
   input  wire logic        [31:0] req_accel_limit,
   input  wire logic               req_linear_move,
   input  wire logic               req_last_axis,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic             [31:0] rsp_move_time,
   output logic                    rsp_bad_limit
);

   state_type   state_ff, state_in;
   logic [31:0] dist_ff, dist_in;
   logic [31:0] speed_ff, speed_in;
   logic [31:0] accel_ff, accel_in;
   logic        last_ff, last_in;
   logic        counted_ff, counted_in;
   logic [2:0]  axis_count_ff, axis_count_in;
   logic [31:0] max_ff, max_in;
   logic        error_ff, error_in;
   logic [63:0] prod_vv_ff, prod_vv_in;
   logic [63:0] prod_sa_ff, prod_sa_in;
   logic [34:0] rem_ff, rem_in;
   logic [63:0] num_ff, num_in;
   logic [63:0] quo_ff, quo_in;
   logic [31:0] den_ff, den_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic [32:0] part_ff, part_in;
   logic [31:0] time_ff, time_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_time_ff, rsp_time_in;
   logic        rsp_bad_ff, rsp_bad_in;

   logic        req_xfer, rsp_xfer, out_free, step_done;
   logic [2:0]  axis_limit;
   logic [31:0] dist_abs, mul_x, mul_y, result_time;
   logic [63:0] mul_p;
   logic        sqrt_mode, step_ge;
   logic [34:0] cand, trial, rem_step;
   logic [35:0] diff;
   logic [63:0] num_step, quo_step;
   logic [32:0] quo_sat, dbl;
   logic [33:0] sum;

   assign req_xfer  = req_valid && !req_stall;
   assign rsp_xfer  = rsp_valid_ff && !rsp_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign step_done = (cnt_ff == 7'd1);
   assign axis_limit = req_linear_move ? LINEAR_AXES : JOINT_AXES;
   assign dist_abs  = req_distance[31] ? 32'(-req_distance) : req_distance;

   // single multiplier, shared by both products of the regime compare
   assign mul_x = (state_ff == ST_MUL_VV) ? speed_ff : dist_ff;
   assign mul_y = (state_ff == ST_MUL_VV) ? speed_ff : accel_ff;
   assign mul_p = mul_x * mul_y;

   // shared restoring divide / square-root step
   assign sqrt_mode = (state_ff == ST_SQRT);
   assign cand  = sqrt_mode ? {rem_ff[32:0], num_ff[63:62]} : {rem_ff[33:0], num_ff[63]};
   assign trial = sqrt_mode ? {1'b0, quo_ff[31:0], 2'b01} : {3'b000, den_ff};
   assign diff  = {1'b0, cand} - {1'b0, trial};
   assign step_ge  = !diff[35];
   assign rem_step = step_ge ? diff[34:0] : cand;
   assign quo_step = {quo_ff[62:0], step_ge};
   assign num_step = sqrt_mode ? {num_ff[61:0], 2'b00} : {num_ff[62:0], 1'b0};

   assign quo_sat = (quo_step[47:32] != 16'd0) ? {1'b1, 32'd0} : {1'b0, quo_step[31:0]};
   assign sum     = {1'b0, part_ff} + {1'b0, quo_sat};
   assign dbl     = {quo_step[31:0], 1'b0};
   assign result_time = (max_ff < TINY_LIMIT_RAW) ? FLOOR_TIME_RAW : max_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (!counted_ff || dist_ff == 32'd0 || speed_ff == 32'd0 || accel_ff == 32'd0)
               state_in = ST_UPDATE;
            else
               state_in = ST_MUL_VV;
         end
         ST_MUL_VV:  state_in = ST_MUL_SA;
         ST_MUL_SA:  state_in = ST_COMPARE;
         ST_COMPARE: begin
            state_in = (prod_vv_ff <= prod_sa_ff) ? ST_DIV_ACCEL : ST_DIV_RATIO;
         end
         ST_DIV_ACCEL: begin
            if (step_done) state_in = ST_DIV_CRUISE;
         end
         ST_DIV_CRUISE: begin
            if (step_done) state_in = ST_UPDATE;
         end
         ST_DIV_RATIO: begin
            if (step_done) state_in = ST_SQRT;
         end
         ST_SQRT: begin
            if (step_done) state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            if (!last_ff || out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath next values
   always_comb begin
      dist_in       = dist_ff;
      speed_in      = speed_ff;
      accel_in      = accel_ff;
      last_in       = last_ff;
      counted_in    = counted_ff;
      axis_count_in = axis_count_ff;
      max_in        = max_ff;
      error_in      = error_ff;
      prod_vv_in    = prod_vv_ff;
      prod_sa_in    = prod_sa_ff;
      rem_in        = rem_ff;
      num_in        = num_ff;
      quo_in        = quo_ff;
      den_in        = den_ff;
      cnt_in        = cnt_ff;
      part_in       = part_ff;
      time_in       = time_ff;
      rsp_valid_in  = rsp_xfer ? 1'b0 : rsp_valid_ff;
      rsp_time_in   = rsp_time_ff;
      rsp_bad_in    = rsp_bad_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               dist_in    = dist_abs;
               speed_in   = req_speed_limit;
               accel_in   = req_accel_limit;
               last_in    = req_last_axis;
               counted_in = (axis_count_ff < axis_limit);
               if (req_last_axis)
                  axis_count_in = 3'd0;
               else if (axis_count_ff < AXIS_COUNT_MAX)
                  axis_count_in = axis_count_ff + 3'd1;
            end
         end
         ST_CHECK: begin
            time_in = 32'd0;
            if (counted_ff && dist_ff != 32'd0 && (speed_ff == 32'd0 || accel_ff == 32'd0))
               error_in = 1'b1;
         end
         ST_MUL_VV: prod_vv_in = mul_p;
         ST_MUL_SA: prod_sa_in = mul_p;
         ST_COMPARE: begin
            rem_in = 35'd0;
            quo_in = 64'd0;
            den_in = accel_ff;
            if (prod_vv_ff <= prod_sa_ff) begin
               num_in = {speed_ff, 32'd0};
               cnt_in = DIV_SHORT_STEPS;
            end else begin
               num_in = {dist_ff, 32'd0};
               cnt_in = DIV_LONG_STEPS;
            end
         end
         ST_DIV_ACCEL: begin
            rem_in = rem_step;
            num_in = num_step;
            quo_in = quo_step;
            cnt_in = cnt_ff - 7'd1;
            if (step_done) begin
               part_in = quo_sat;
               rem_in  = 35'd0;
               quo_in  = 64'd0;
               num_in  = {dist_ff, 32'd0};
               den_in  = speed_ff;
               cnt_in  = DIV_SHORT_STEPS;
            end
         end
         ST_DIV_CRUISE: begin
            rem_in = rem_step;
            num_in = num_step;
            quo_in = quo_step;
            cnt_in = cnt_ff - 7'd1;
            if (step_done)
               time_in = (sum[33:32] != 2'd0) ? 32'hFFFF_FFFF : sum[31:0];
         end
         ST_DIV_RATIO: begin
            rem_in = rem_step;
            num_in = num_step;
            quo_in = quo_step;
            cnt_in = cnt_ff - 7'd1;
            // quotient becomes the radicand
            if (step_done) begin
               num_in = quo_step;
               rem_in = 35'd0;
               quo_in = 64'd0;
               cnt_in = SQRT_STEPS;
            end
         end
         ST_SQRT: begin
            rem_in = rem_step;
            num_in = num_step;
            quo_in = quo_step;
            cnt_in = cnt_ff - 7'd1;
            if (step_done)
               time_in = dbl[32] ? 32'hFFFF_FFFF : dbl[31:0];
         end
         ST_UPDATE: begin
            if (counted_ff && time_ff > max_ff) max_in = time_ff;
            if (last_ff && out_free) begin
               rsp_valid_in = 1'b1;
               // floor applies to the maximum including this axis
               if (counted_ff && time_ff > max_ff)
                  rsp_time_in = (time_ff < TINY_LIMIT_RAW) ? FLOOR_TIME_RAW : time_ff;
               else
                  rsp_time_in = result_time;
               rsp_bad_in   = error_ff;
               max_in       = 32'd0;
               error_in     = 1'b0;
            end
         end
         default: ;
      endcase
   end

   // outputs
   always_comb begin
      req_stall     = (state_ff != ST_IDLE);
      rsp_valid     = rsp_valid_ff;
      rsp_move_time = rsp_time_ff;
      rsp_bad_limit = rsp_bad_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         axis_count_ff <= 3'd0;
         max_ff        <= 32'd0;
         error_ff      <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         cnt_ff        <= 7'd0;
      end else begin
         state_ff      <= state_in;
         axis_count_ff <= axis_count_in;
         max_ff        <= max_in;
         error_ff      <= error_in;
         rsp_valid_ff  <= rsp_valid_in;
         cnt_ff        <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      dist_ff     <= dist_in;
      speed_ff    <= speed_in;
      accel_ff    <= accel_in;
      last_ff     <= last_in;
      counted_ff  <= counted_in;
      prod_vv_ff  <= prod_vv_in;
      prod_sa_ff  <= prod_sa_in;
      rem_ff      <= rem_in;
      num_ff      <= num_in;
      quo_ff      <= quo_in;
      den_ff      <= den_in;
      part_ff     <= part_in;
      time_ff     <= time_in;
      rsp_time_ff <= rsp_time_in;
      rsp_bad_ff  <= rsp_bad_in;
   end

`ifndef ASSERT_OFF
   // iterating states always have steps left
   a_steps_left: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV_ACCEL || state_ff == ST_DIV_CRUISE ||
       state_ff == ST_DIV_RATIO || state_ff == ST_SQRT) |-> cnt_ff != 7'd0)
      else $error("shared unit running with no steps left");

   // a finished last axis posts its result
   a_result_posted: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_UPDATE && last_ff && out_free) |=> rsp_valid_ff)
      else $error("last axis finished without a result");

   // the floor on tiny times always applies
   a_floor: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_time_ff >= TINY_LIMIT_RAW)
      else $error("result below the tiny time floor");
`endif

endmodule

`default_nettype wire
